### hw/rtl/mrfd_pkg.sv
// Shared types, constants and register map for the motor reply frame decoder.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package mrfd_pkg;

  // Torque smoothing window (a power of two, 1 .. 64)
  localparam int SMOOTH_DEPTH = 8;
  localparam int MEAN_SHIFT   = $clog2(SMOOTH_DEPTH);
  localparam int MEAN_HALF    = SMOOTH_DEPTH / 2;
  localparam int SUM_W        = 32 + MEAN_SHIFT + 1;

  // Code mapping widths
  localparam int CODE_W      = 16;
  localparam int SPAN_W      = 33;
  localparam int PROD_W      = CODE_W + 1 + SPAN_W;
  localparam int MAG_W       = PROD_W - 1;
  localparam int QUO_W       = 33;
  localparam int OFS_W       = QUO_W + 1;
  localparam int FOLD_STAGES = 3;

  localparam int WIDE_SHIFT   = 16;
  localparam int NARROW_SHIFT = 12;
  localparam int WIDE_DIV     = (1 << WIDE_SHIFT) - 1;
  localparam int NARROW_DIV   = (1 << NARROW_SHIFT) - 1;
  localparam int WIDE_HALF    = WIDE_DIV / 2;
  localparam int NARROW_HALF  = NARROW_DIV / 2;

  // Speed times ten
  localparam int SPD_W = 36;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Mapping lanes
  localparam int N_LANES  = 3;
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_TRQ = 2;

  // Pipeline stage positions
  localparam int LANE_LAT   = FOLD_STAGES + 4;
  localparam int ST_MAP     = LANE_LAT;
  localparam int ST_RING    = ST_MAP + 1;
  localparam int ST_SUM     = ST_MAP + 2;
  localparam int ST_MEAN    = ST_MAP + 3;
  localparam int PIPE_DEPTH = ST_MEAN + 1;

  // Register map
  localparam int N_REGS    = 7;
  localparam int ADDR_W    = $clog2(N_REGS * 4);
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_MOTOR_ID   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_POS_MIN    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_POS_MAX    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_VEL_MIN    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_VEL_MAX    = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_TORQUE_MIN = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_TORQUE_MAX = REG_IDX_W'(6);

  localparam logic [7:0]         MOTOR_ID_RST   = 8'd1;
  localparam logic signed [31:0] POS_MIN_RST    = -32'sd819200;
  localparam logic signed [31:0] POS_MAX_RST    = 32'sd819200;
  localparam logic signed [31:0] VEL_MIN_RST    = -32'sd2949120;
  localparam logic signed [31:0] VEL_MAX_RST    = 32'sd2949120;
  localparam logic signed [31:0] TORQUE_MIN_RST = -32'sd1179648;
  localparam logic signed [31:0] TORQUE_MAX_RST = 32'sd1179648;

  typedef struct packed {
    logic [7:0] node_byte;
    logic [7:0] pos_high_byte;
    logic [7:0] pos_low_byte;
    logic [7:0] vel_high_byte;
    logic [7:0] vel_torque_byte;
    logic [7:0] torque_low_byte;
    logic [7:0] fault_high_byte;
    logic [7:0] fault_low_byte;
  } frame_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] torque;
    logic signed [31:0] mean_torque;
    logic [15:0]        fault_word;
    logic               speed_clipped;
  } reply_t;

  // Partial quotient and remainder handed along the fold chain
  typedef struct packed {
    logic             neg;
    logic [QUO_W-1:0] q;
    logic [MAG_W-1:0] r;
  } fold_t;

endpackage

`default_nettype wire

### hw/rtl/mrfd_fold_cell.sv
// One step of division by 2^k - 1: fold the high part of the remainder onto
// the low part and add it to the quotient. Depends on mrfd_pkg.
`default_nettype none

module mrfd_fold_cell import mrfd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire logic  wide_i,
  input  wire fold_t fold_i,
  output fold_t      fold_o
);

  logic [MAG_W-1:0] hi;
  logic [MAG_W-1:0] lo;
  logic [MAG_W-1:0] qsum;
  fold_t            fold_d;
  fold_t            fold_q;

  always_comb begin
    hi          = wide_i ? (fold_i.r >> WIDE_SHIFT) : (fold_i.r >> NARROW_SHIFT);
    lo          = wide_i ? MAG_W'(fold_i.r[WIDE_SHIFT-1:0])
                         : MAG_W'(fold_i.r[NARROW_SHIFT-1:0]);
    qsum        = MAG_W'(fold_i.q) + hi;
    fold_d.neg  = fold_i.neg;
    fold_d.q    = qsum[QUO_W-1:0];
    fold_d.r    = lo + hi;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= fold_d;
    end
  end

  assign fold_o = fold_q;

endmodule

`default_nettype wire

### hw/rtl/mrfd_map_lane.sv
// Maps one raw code onto [lo, lo + span] with round-half-away division by
// 2^k - 1, built as a multiply, a chain of fold cells and a fix-up.
// Depends on mrfd_pkg and mrfd_fold_cell.
`default_nettype none

module mrfd_map_lane import mrfd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     wide_i,
  input  wire logic [CODE_W-1:0]        code_i,
  input  wire logic signed [SPAN_W-1:0] span_i,
  input  wire logic signed [31:0]       lo_i,
  output logic signed [31:0]            value_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        half;
  logic                     prod_neg;
  fold_t                    fold_d;
  fold_t                    fold0_q;
  fold_t                    fold_w [FOLD_STAGES+1];
  logic [MAG_W-1:0]         div;
  logic [QUO_W-1:0]         qc_d, qc_q;
  logic                     neg_q;
  logic [OFS_W-1:0]         lo_x, q_x, ofs_sum;
  logic signed [31:0]       value_d, value_q;

  // Multiply
  always_comb begin
    prod_d = $signed({1'b0, code_i}) * span_i;
  end

  // Magnitude plus half divisor
  always_comb begin
    prod_neg   = prod_q[PROD_W-1];
    half       = wide_i ? PROD_W'(WIDE_HALF) : PROD_W'(NARROW_HALF);
    mag        = (prod_q ^ {PROD_W{prod_neg}}) + PROD_W'(prod_neg) + half;
    fold_d.neg = prod_neg;
    fold_d.q   = '0;
    fold_d.r   = mag[MAG_W-1:0];
  end

  assign fold_w[0] = fold0_q;

  for (genvar i = 0; i < FOLD_STAGES; i++) begin : g_fold
    mrfd_fold_cell u_fold (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .wide_i (wide_i),
      .fold_i (fold_w[i]),
      .fold_o (fold_w[i+1])
    );
  end

  // Remainder now below twice the divisor: one compare finishes the quotient
  always_comb begin
    div  = wide_i ? MAG_W'(WIDE_DIV) : MAG_W'(NARROW_DIV);
    qc_d = fold_w[FOLD_STAGES].q + QUO_W'(fold_w[FOLD_STAGES].r >= div);
  end

  // Offset by lo; result stays inside [min, max] so the low 32 bits are exact
  always_comb begin
    lo_x    = OFS_W'(lo_i);
    q_x     = OFS_W'(qc_q);
    ofs_sum = lo_x + (q_x ^ {OFS_W{neg_q}}) + OFS_W'(neg_q);
    value_d = ofs_sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      fold0_q <= fold_d;
      qc_q    <= qc_d;
      neg_q   <= fold_w[FOLD_STAGES].neg;
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

### hw/rtl/mrfd_tap_cell.sv
// One entry of the torque history line: holds a value and passes it on to
// the next cell on each shift. Depends on mrfd_pkg.
`default_nettype none

module mrfd_tap_cell import mrfd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               shift_i,
  input  wire logic signed [31:0] d_i,
  output logic signed [31:0]      q_o
);

  logic signed [31:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (shift_i) begin
      value_q <= d_i;
    end
  end

  assign q_o = value_q;

endmodule

`default_nettype wire

### hw/rtl/motor_reply_frame_decoder_core.sv
// Top level of the motor reply frame decoder: config registers, id filter,
// mapping lanes, speed scaling, torque history, mean and output skid buffer.
// Depends on mrfd_pkg, mrfd_map_lane and mrfd_tap_cell.
//
//   channel | direction | handshake                     | payload
//   --------+-----------+-------------------------------+------------------
//   in      | sink      | in_valid_i / in_stall_o       | in_data_i  frame_t
//   out     | source    | out_valid_o / out_stall_i     | out_data_o reply_t
//   config  | sink      | psel penable pwrite / pready  | paddr pwdata prdata
//
// One frame is taken per clock while in_stall_o is low. A frame that carries
// the configured id gives its transaction on out after the input register, the
// multiply, round, three fold cells, fix-up and offset of the mapping lanes,
// the ring, sum and mean stages. Other frames are dropped at the input.
// Reset clears the control state and the torque line and sets config defaults.
// A stall on out parks one transaction in the skid register; in_stall_o is
// that register's valid flag, so in stalls the cycle after, holding all stages.
`default_nettype none

module motor_reply_frame_decoder_core import mrfd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input frames
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire frame_t            in_data_i,
  // decoded replies
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output reply_t                 out_data_o,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                   cfg_we;
  logic [REG_IDX_W-1:0]   cfg_idx;
  logic [7:0]             motor_id_q;
  logic signed [31:0]     min_q  [N_LANES];
  logic signed [31:0]     max_q  [N_LANES];
  logic signed [SPAN_W-1:0] span_q [N_LANES];

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q      <= MOTOR_ID_RST;
      min_q[LANE_POS] <= POS_MIN_RST;
      max_q[LANE_POS] <= POS_MAX_RST;
      min_q[LANE_VEL] <= VEL_MIN_RST;
      max_q[LANE_VEL] <= VEL_MAX_RST;
      min_q[LANE_TRQ] <= TORQUE_MIN_RST;
      max_q[LANE_TRQ] <= TORQUE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MOTOR_ID:   motor_id_q      <= pwdata[7:0];
        REG_POS_MIN:    min_q[LANE_POS] <= pwdata;
        REG_POS_MAX:    max_q[LANE_POS] <= pwdata;
        REG_VEL_MIN:    min_q[LANE_VEL] <= pwdata;
        REG_VEL_MAX:    max_q[LANE_VEL] <= pwdata;
        REG_TORQUE_MIN: min_q[LANE_TRQ] <= pwdata;
        REG_TORQUE_MAX: max_q[LANE_TRQ] <= pwdata;
        default: ;  // unmapped address, drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MOTOR_ID:   prdata = {24'd0, motor_id_q};
      REG_POS_MIN:    prdata = min_q[LANE_POS];
      REG_POS_MAX:    prdata = max_q[LANE_POS];
      REG_VEL_MIN:    prdata = min_q[LANE_VEL];
      REG_VEL_MAX:    prdata = max_q[LANE_VEL];
      REG_TORQUE_MIN: prdata = min_q[LANE_TRQ];
      REG_TORQUE_MAX: prdata = max_q[LANE_TRQ];
      default:        prdata = '0;
    endcase
  end

  // Spans at 33 bits; user must ensure config moves only while idle (unenforced)
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < N_LANES; l++) begin
      span_q[l] <= SPAN_W'(max_q[l]) - SPAN_W'(min_q[l]);
    end
  end

  // ---------------------------------------------------------------------
  // Input stage and id filter
  // ---------------------------------------------------------------------
  logic                  en;
  logic                  in_take;
  logic                  id_match;
  logic [PIPE_DEPTH-1:0] v_q;
  logic [CODE_W-1:0]     code_d [N_LANES];
  logic [CODE_W-1:0]     code_q [N_LANES];
  logic [15:0]           fault_q [PIPE_DEPTH];
  logic skid_valid_q, skid_valid_d;

  // Advance every stage unless the skid register is occupied
  assign en         = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign id_match   = (in_data_i.node_byte == motor_id_q);

  always_comb begin
    code_d[LANE_POS] = {in_data_i.pos_high_byte, in_data_i.pos_low_byte};
    code_d[LANE_VEL] = CODE_W'({in_data_i.vel_high_byte, in_data_i.vel_torque_byte[7:4]});
    code_d[LANE_TRQ] = CODE_W'({in_data_i.vel_torque_byte[3:0], in_data_i.torque_low_byte});
  end

  // Foreign ids enter as bubbles: no result, no state change
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], in_take & id_match};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      code_q     <= code_d;
      fault_q[0] <= {in_data_i.fault_high_byte, in_data_i.fault_low_byte};
      for (int s = 1; s < PIPE_DEPTH; s++) begin
        fault_q[s] <= fault_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Mapping lanes: position, speed, torque
  // ---------------------------------------------------------------------
  logic signed [31:0] lane_val [N_LANES];

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    mrfd_map_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .wide_i  (l == LANE_POS),
      .code_i  (code_q[l]),
      .span_i  (span_q[l]),
      .lo_i    (min_q[l]),
      .value_o (lane_val[l])
    );
  end

  // ---------------------------------------------------------------------
  // Ring stage: speed times ten, torque history shift, sum delta
  // ---------------------------------------------------------------------
  logic signed [SPD_W-1:0] vel_x, spd_x10;
  logic                    spd_ovf;
  logic signed [31:0]      spd_d;
  logic                    ring_shift;
  logic signed [31:0]      tap_w [SMOOTH_DEPTH+1];
  logic signed [32:0]      diff_d, diff_q;
  logic signed [31:0]      pos8_q, spd8_q, trq8_q;
  logic                    clip8_q;

  always_comb begin
    vel_x   = SPD_W'(lane_val[LANE_VEL]);
    spd_x10 = (vel_x <<< 3) + (vel_x <<< 1);
    // clip when the top bits disagree with the 32-bit sign
    spd_ovf = (spd_x10[SPD_W-1:31] != {(SPD_W-31){spd_x10[SPD_W-1]}});
    if (spd_ovf) begin
      spd_d = spd_x10[SPD_W-1] ? S32_MIN : S32_MAX;
    end else begin
      spd_d = spd_x10[31:0];
    end
  end

  // Newest torque enters the head; the oldest falls off the tail
  assign ring_shift = en & v_q[ST_MAP];
  assign tap_w[0]   = lane_val[LANE_TRQ];

  for (genvar t = 0; t < SMOOTH_DEPTH; t++) begin : g_tap
    mrfd_tap_cell u_tap (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring_shift),
      .d_i     (tap_w[t]),
      .q_o     (tap_w[t+1])
    );
  end

  assign diff_d = 33'(lane_val[LANE_TRQ]) - 33'(tap_w[SMOOTH_DEPTH]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos8_q  <= lane_val[LANE_POS];
      spd8_q  <= spd_d;
      clip8_q <= spd_ovf;
      trq8_q  <= lane_val[LANE_TRQ];
      diff_q  <= diff_d;
    end
  end

  // ---------------------------------------------------------------------
  // Sum stage: running sum of the history line
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_q;
  logic signed [31:0]      pos9_q, spd9_q, trq9_q;
  logic                    clip9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en && v_q[ST_RING]) begin
      sum_q <= sum_q + SUM_W'(diff_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos9_q  <= pos8_q;
      spd9_q  <= spd8_q;
      clip9_q <= clip8_q;
      trq9_q  <= trq8_q;
    end
  end

  // ---------------------------------------------------------------------
  // Mean stage: magnitude plus half, then shift and restore sign.
  // sum_q already holds this transaction's torque and no later one.
  // ---------------------------------------------------------------------
  logic                    sum_neg;
  logic [SUM_W-1:0]        mm_d, mm_q, mq;
  logic                    mneg_q;
  logic signed [31:0]      pos10_q, spd10_q, trq10_q;
  logic                    clip10_q;
  logic [SUM_W-1:0]        mean_x;
  reply_t                  res_d;

  always_comb begin
    sum_neg = sum_q[SUM_W-1];
    mm_d    = (sum_q ^ {SUM_W{sum_neg}}) + SUM_W'(sum_neg) + SUM_W'(MEAN_HALF);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mm_q     <= mm_d;
      mneg_q   <= sum_neg;
      pos10_q  <= pos9_q;
      spd10_q  <= spd9_q;
      clip10_q <= clip9_q;
      trq10_q  <= trq9_q;
    end
  end

  always_comb begin
    mq     = mm_q >> MEAN_SHIFT;
    mean_x = mneg_q ? (~mq + SUM_W'(1)) : mq;
    res_d.position      = pos10_q;
    res_d.speed         = spd10_q;
    res_d.torque        = trq10_q;
    res_d.mean_torque   = mean_x[31:0];
    res_d.fault_word    = fault_q[ST_MEAN];
    res_d.speed_clipped = clip10_q;
  end

  // ---------------------------------------------------------------------
  // Output register and skid register
  // ---------------------------------------------------------------------
  logic   out_valid_q, out_valid_d;
  logic   arrive, take;
  reply_t out_q, skid_q;

  assign arrive = en & v_q[ST_MEAN];
  assign take   = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    priority if (skid_valid_q) begin
      // drain the skid into the output slot
      if (take) begin
        skid_valid_d = 1'b0;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
